@@ rtl/core/rmd128_pkg.sv @@
// package with ripemd-128 constants, schedule tables and round functions
package rmd128_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned CountW = 61;

	localparam logic [WordW-1:0] IvA = 32'h67452301;
	localparam logic [WordW-1:0] IvB = 32'hEFCDAB89;
	localparam logic [WordW-1:0] IvC = 32'h98BADCFE;
	localparam logic [WordW-1:0] IvD = 32'h10325476;
	localparam logic [7:0] PadByte = 8'h80;

	typedef logic [WordW-1:0] word_t;

	function automatic logic [3:0] left_word(input logic [5:0] i);
		logic [3:0] t [64];
		t = '{4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,4'd14,4'd15,
			4'd7,4'd4,4'd13,4'd1,4'd10,4'd6,4'd15,4'd3,4'd12,4'd0,4'd9,4'd5,4'd2,4'd14,4'd11,4'd8,
			4'd3,4'd10,4'd14,4'd4,4'd9,4'd15,4'd8,4'd1,4'd2,4'd7,4'd0,4'd6,4'd13,4'd11,4'd5,4'd12,
			4'd1,4'd9,4'd11,4'd10,4'd0,4'd8,4'd12,4'd4,4'd13,4'd3,4'd7,4'd15,4'd14,4'd5,4'd6,4'd2};
		return t[i];
	endfunction

	function automatic logic [3:0] right_word(input logic [5:0] i);
		logic [3:0] t [64];
		t = '{4'd5,4'd14,4'd7,4'd0,4'd9,4'd2,4'd11,4'd4,4'd13,4'd6,4'd15,4'd8,4'd1,4'd10,4'd3,4'd12,
			4'd6,4'd11,4'd3,4'd7,4'd0,4'd13,4'd5,4'd10,4'd14,4'd15,4'd8,4'd12,4'd4,4'd9,4'd1,4'd2,
			4'd15,4'd5,4'd1,4'd3,4'd7,4'd14,4'd6,4'd9,4'd11,4'd8,4'd12,4'd2,4'd10,4'd0,4'd4,4'd13,
			4'd8,4'd6,4'd4,4'd1,4'd3,4'd11,4'd15,4'd0,4'd5,4'd12,4'd2,4'd13,4'd9,4'd7,4'd10,4'd14};
		return t[i];
	endfunction

	function automatic logic [4:0] left_rot(input logic [5:0] i);
		logic [4:0] t [64];
		t = '{5'd11,5'd14,5'd15,5'd12,5'd5,5'd8,5'd7,5'd9,5'd11,5'd13,5'd14,5'd15,5'd6,5'd7,5'd9,5'd8,
			5'd7,5'd6,5'd8,5'd13,5'd11,5'd9,5'd7,5'd15,5'd7,5'd12,5'd15,5'd9,5'd11,5'd7,5'd13,5'd12,
			5'd11,5'd13,5'd6,5'd7,5'd14,5'd9,5'd13,5'd15,5'd14,5'd8,5'd13,5'd6,5'd5,5'd12,5'd7,5'd5,
			5'd11,5'd12,5'd14,5'd15,5'd14,5'd15,5'd9,5'd8,5'd9,5'd14,5'd5,5'd6,5'd8,5'd6,5'd5,5'd12};
		return t[i];
	endfunction

	function automatic logic [4:0] right_rot(input logic [5:0] i);
		logic [4:0] t [64];
		t = '{5'd8,5'd9,5'd9,5'd11,5'd13,5'd15,5'd15,5'd5,5'd7,5'd7,5'd8,5'd11,5'd14,5'd14,5'd12,5'd6,
			5'd9,5'd13,5'd15,5'd7,5'd12,5'd8,5'd9,5'd11,5'd7,5'd7,5'd12,5'd7,5'd6,5'd15,5'd13,5'd11,
			5'd9,5'd7,5'd15,5'd11,5'd8,5'd6,5'd6,5'd14,5'd12,5'd13,5'd5,5'd14,5'd13,5'd13,5'd7,5'd5,
			5'd15,5'd5,5'd8,5'd11,5'd14,5'd14,5'd6,5'd14,5'd6,5'd9,5'd12,5'd9,5'd12,5'd5,5'd15,5'd8};
		return t[i];
	endfunction

	function automatic word_t left_k(input logic [1:0] r);
		case (r)
			2'd0: return 32'h00000000;
			2'd1: return 32'h5A827999;
			2'd2: return 32'h6ED9EBA1;
			default: return 32'h8F1BBCDC;
		endcase
	endfunction

	function automatic word_t right_k(input logic [1:0] r);
		case (r)
			2'd0: return 32'h50A28BE6;
			2'd1: return 32'h5C4DD124;
			2'd2: return 32'h6D703EF3;
			default: return 32'h00000000;
		endcase
	endfunction

	function automatic word_t round_fn(input logic [1:0] sel, input word_t b, input word_t c,
		input word_t d);
		case (sel)
			2'd0: return b ^ c ^ d;
			2'd1: return (b & c) | (~b & d);
			2'd2: return (b | ~c) ^ d;
			default: return (b & d) | (c & ~d);
		endcase
	endfunction

	function automatic word_t rotl(input word_t v, input logic [4:0] s);
		logic [2*WordW-1:0] x;
		x = {v, v} << s;
		return x[2*WordW-1:WordW];
	endfunction

endpackage

@@ rtl/core/rmd128_compress.sv @@
// compression unit: block memory and a shared step unit that advances both lines together, one step at a time
module rmd128_compress (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [5:0]          wr_addr,
	input  logic [7:0]          wr_data,
	input  logic                start,
	input  logic                init,
	output logic                busy,
	output rmd128_pkg::word_t   chain [4]
);
	import rmd128_pkg::*;

	word_t mem_q [16];
	word_t mem_rd_q;
	word_t chain_q [4];
	word_t la_q, lb_q, lc_q, ld_q, ra_q, rb_q, rc_q, rd_q;
	word_t lw_q;
	logic [6:0] idx_q;
	logic [1:0] phase_q;
	logic running_q;
	logic [5:0] step;
	logic [3:0] wsel;
	word_t lt, rt, rw;
	logic [1:0] rnd;

	// phase 0,1: fetch left and right words; phase 2: step
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr[5:2]][8*wr_addr[1:0] +: 8] <= wr_data;
		mem_rd_q <= mem_q[wsel];
	end

	assign step = idx_q[5:0];
	assign rnd = step[5:4];
	assign wsel = (phase_q == 2'd0) ? left_word(step) : right_word(step);
	assign rw = mem_rd_q;

	assign lt = rotl(la_q + round_fn(rnd, lb_q, lc_q, ld_q) + lw_q + left_k(rnd),
		left_rot(step));
	assign rt = rotl(ra_q + round_fn(2'd3 - rnd, rb_q, rc_q, rd_q) + rw + right_k(rnd),
		right_rot(step));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			idx_q <= '0;
			phase_q <= '0;
			chain_q[0] <= IvA;
			chain_q[1] <= IvB;
			chain_q[2] <= IvC;
			chain_q[3] <= IvD;
		end else if (init) begin
			chain_q[0] <= IvA;
			chain_q[1] <= IvB;
			chain_q[2] <= IvC;
			chain_q[3] <= IvD;
		end else if (start) begin
			running_q <= 1'b1;
			idx_q <= '0;
			phase_q <= '0;
		end else if (running_q) begin
			if (idx_q[6]) begin
				chain_q[0] <= chain_q[1] + lc_q + rd_q;
				chain_q[1] <= chain_q[2] + ld_q + ra_q;
				chain_q[2] <= chain_q[3] + la_q + rb_q;
				chain_q[3] <= chain_q[0] + lb_q + rc_q;
				running_q <= 1'b0;
			end else begin
				case (phase_q)
					2'd0: phase_q <= 2'd1;
					2'd1: phase_q <= 2'd2;
					default: begin
						phase_q <= 2'd0;
						idx_q <= idx_q + 7'd1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			la_q <= chain_q[0]; lb_q <= chain_q[1]; lc_q <= chain_q[2]; ld_q <= chain_q[3];
			ra_q <= chain_q[0]; rb_q <= chain_q[1]; rc_q <= chain_q[2]; rd_q <= chain_q[3];
		end else if (running_q && !idx_q[6]) begin
			if (phase_q == 2'd1)
				lw_q <= rw;
			if (phase_q == 2'd2) begin
				la_q <= ld_q; ld_q <= lc_q; lc_q <= lb_q; lb_q <= lt;
				ra_q <= rd_q; rd_q <= rc_q; rc_q <= rb_q; rb_q <= rt;
			end
		end
	end

	assign busy = running_q;
	assign chain = chain_q;
endmodule

@@ rtl/core/ripemd128_hash.sv @@
// top level: byte intake, padding sequencer and digest output register
// each byte is accepted in idle and written to block memory in the byte state;
// intake stalls while a block compresses. end of message: pad and length bytes
// are written in turn, then one or two compressions; 64 shared steps per block
// reset: asynchronous, clears counts and loads the initial chaining words
// the block memory holds no reset value
module ripemd128_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  msg_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word_0,
	output logic [31:0] digest_word_1,
	output logic [31:0] digest_word_2,
	output logic [31:0] digest_word_3
);
	import rmd128_pkg::*;

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StByte = 3'd1;
	localparam logic [2:0] StPad  = 3'd2;
	localparam logic [2:0] StWait = 3'd3;
	localparam logic [2:0] StDone = 3'd4;

	logic [2:0] state_q;
	logic [CountW-1:0] count_q;
	logic [63:0] bits_q;
	logic [7:0] byte_q;
	logic end_q, pad_first_q, pad_len_q, fin_q;
	logic [2:0] len_idx_q;
	logic wr_en, start, init, busy;
	logic [7:0] wr_data;
	word_t chain [4];
	logic oval_q;
	logic accept;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != StIdle);

	always_comb begin
		wr_en = 1'b0;
		wr_data = byte_q;
		case (state_q)
			StByte: wr_en = 1'b1;
			StPad: begin
				wr_en = 1'b1;
				if (pad_first_q)
					wr_data = PadByte;
				else if (pad_len_q)
					wr_data = bits_q[8*len_idx_q +: 8];
				else
					wr_data = 8'h00;
			end
			default: ;
		endcase
	end
	assign start = wr_en && (count_q[5:0] == 6'd63);
	assign init = (state_q == StDone) && !oval_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			count_q <= '0;
			oval_q <= 1'b0;
			end_q <= 1'b0;
			pad_first_q <= 1'b0;
			pad_len_q <= 1'b0;
			len_idx_q <= '0;
			fin_q <= 1'b0;
		end else begin
			if (oval_q && !out_stall)
				oval_q <= 1'b0;
			if (wr_en)
				count_q <= count_q + CountW'(1);
			case (state_q)
				StIdle: begin
					if (accept) begin
						end_q <= end_of_message;
						if (byte_present)
							state_q <= StByte;
						else if (end_of_message) begin
							state_q <= StPad;
							pad_first_q <= 1'b1;
							pad_len_q <= 1'b0;
							len_idx_q <= '0;
						end
					end
				end
				StByte: begin
					if (start) begin
						state_q <= StWait;
						if (end_q) begin
							pad_first_q <= 1'b1;
							pad_len_q <= 1'b0;
							len_idx_q <= '0;
						end
					end else if (end_q) begin
						state_q <= StPad;
						pad_first_q <= 1'b1;
						pad_len_q <= 1'b0;
						len_idx_q <= '0;
					end else
						state_q <= StIdle;
				end
				StPad: begin
					pad_first_q <= 1'b0;
					if (pad_len_q)
						len_idx_q <= len_idx_q + 3'd1;
					if (count_q[5:0] == 6'd55)
						pad_len_q <= 1'b1;
					if (start) begin
						fin_q <= pad_len_q && (len_idx_q == 3'd7);
						state_q <= StWait;
					end
				end
				StWait: begin
					if (!busy && !start) begin
						if (fin_q) begin
							fin_q <= 1'b0;
							state_q <= StDone;
						end else if (end_q)
							state_q <= StPad;
						else
							state_q <= StIdle;
					end
				end
				StDone: begin
					if (!oval_q) begin
						oval_q <= 1'b1;
						end_q <= 1'b0;
						count_q <= '0;
						state_q <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// byte, length and digest capture
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= msg_byte;
			if (byte_present)
				bits_q <= {count_q + CountW'(1), 3'b000};
			else
				bits_q <= {count_q, 3'b000};
		end
		if (init) begin
			digest_word_0 <= chain[0];
			digest_word_1 <= chain[1];
			digest_word_2 <= chain[2];
			digest_word_3 <= chain[3];
		end
	end

	assign out_valid = oval_q;

	rmd128_compress u_compress (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (count_q[5:0]),
		.wr_data (wr_data),
		.start   (start),
		.init    (init),
		.busy    (busy),
		.chain   (chain)
	);
endmodule

@@ tb/ripemd128_hash_checker.sv @@
// digest checker: watches both channels, predicts ripemd-128 digests and compares them
`timescale 1ns / 100ps
module ripemd128_hash_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  msg_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] digest_word_0,
	input  logic [31:0] digest_word_1,
	input  logic [31:0] digest_word_2,
	input  logic [31:0] digest_word_3,
	output int          mismatches,
	output int          pending_digests,
	output int          digests_seen
);
	import rmd128_pkg::*;

	typedef logic [127:0] digest_t;

	localparam logic [3:0] LeftSel [64] = '{
		0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15, 7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
		3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12, 1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2};
	localparam logic [4:0] LeftShift [64] = '{
		11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8, 7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
		11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5, 11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12};
	localparam logic [3:0] RightSel [64] = '{
		5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12, 6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
		15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13, 8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14};
	localparam logic [4:0] RightShift [64] = '{
		8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6, 9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
		9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5, 15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8};
	localparam word_t LeftConst [4] = '{32'h0, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC};
	localparam word_t RightConst [4] = '{32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h0};

	word_t       chain [4];
	logic [7:0]  block_buf [64];
	logic [60:0] byte_count;
	digest_t     expected_digests [$];

	function automatic word_t rol32(word_t v, logic [4:0] s);
		logic [63:0] x;
		x = {v, v} << s;
		return x[63:32];
	endfunction

	function automatic word_t mix_fn(logic [1:0] sel, word_t b, word_t c, word_t d);
		case (sel)
			2'd0: return b ^ c ^ d;
			2'd1: return (b & c) | (~b & d);
			2'd2: return (b | ~c) ^ d;
			default: return (b & d) | (c & ~d);
		endcase
	endfunction

	task automatic compress_block();
		word_t w [16];
		word_t la, lb, lc, ld, ra, rb, rc, rd, t, n;
		logic [1:0] r;
		for (int i = 0; i < 16; i++)
			w[i] = {block_buf[4*i+3], block_buf[4*i+2], block_buf[4*i+1], block_buf[4*i]};
		la = chain[0]; lb = chain[1]; lc = chain[2]; ld = chain[3];
		ra = la; rb = lb; rc = lc; rd = ld;
		for (int i = 0; i < 64; i++) begin
			r = i[5:4];
			t = rol32(la + mix_fn(r, lb, lc, ld) + w[LeftSel[i]] + LeftConst[r], LeftShift[i]);
			la = ld; ld = lc; lc = lb; lb = t;
			t = rol32(ra + mix_fn(2'd3 - r, rb, rc, rd) + w[RightSel[i]] + RightConst[r],
				RightShift[i]);
			ra = rd; rd = rc; rc = rb; rb = t;
		end
		n = chain[1] + lc + rd;
		chain[1] = chain[2] + ld + ra;
		chain[2] = chain[3] + la + rb;
		chain[3] = chain[0] + lb + rc;
		chain[0] = n;
	endtask

	task automatic absorb_byte(logic [7:0] b);
		logic [5:0] pos;
		pos = byte_count[5:0];
		block_buf[pos] = b;
		byte_count = byte_count + 61'd1;
		if (pos == 6'd63)
			compress_block();
	endtask

	task automatic restart_chain();
		chain[0] = IvA; chain[1] = IvB; chain[2] = IvC; chain[3] = IvD;
		byte_count = '0;
	endtask

	task automatic take_transfer(logic [7:0] b, logic has_byte, logic last);
		logic [63:0] bit_len;
		digest_t next_digest;
		if (has_byte)
			absorb_byte(b);
		if (last) begin
			bit_len = {byte_count, 3'b000};
			absorb_byte(PadByte);
			while (byte_count[5:0] != 6'd56)
				absorb_byte(8'h00);
			for (int i = 0; i < 8; i++)
				absorb_byte(bit_len[8*i +: 8]);
			next_digest = {chain[3], chain[2], chain[1], chain[0]};
			expected_digests = {expected_digests, next_digest};
			restart_chain();
		end
	endtask

	assign pending_digests = expected_digests.size();

	always @(posedge clk or negedge arst_n) begin
		digest_t want, got;
		if (!arst_n) begin
			restart_chain();
			expected_digests.delete();
			mismatches <= 0;
			digests_seen <= 0;
		end else begin
			if (in_valid && !in_stall)
				take_transfer(msg_byte, byte_present, end_of_message);
			if (out_valid && !out_stall) begin
				got = {digest_word_3, digest_word_2, digest_word_1, digest_word_0};
				digests_seen <= digests_seen + 1;
				if (expected_digests.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected digest %h", got);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_digests.pop_front();
					if (want != got) begin
						if (mismatches < 10)
							$display("digest mismatch: expected w0..w3 %h %h %h %h, got %h %h %h %h",
								want[31:0], want[63:32], want[95:64], want[127:96],
								got[31:0], got[63:32], got[95:64], got[127:96]);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < 64; i++)
			block_buf[i] = 8'h00;
	end
endmodule

@@ tb/ripemd128_hash_tb.sv @@
// testbench top: clock, reset, byte stream stimulus and verdict for ripemd128_hash
`timescale 1ns / 100ps
module ripemd128_hash_tb;
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  msg_byte;
	logic        byte_present;
	logic        end_of_message;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] digest_word_0, digest_word_1, digest_word_2, digest_word_3;
	int          mismatches, pending_digests, digests_seen;
	int          send_idle_pct, recv_idle_pct;
	int          items_sent, messages_sent, idle_cycles;

	localparam int StallLimit = 200000;

	ripemd128_hash u_dut (.*);

	ripemd128_hash_checker u_checker (.*);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("watchdog: no transfer for %0d cycles", idle_cycles);
			$display("ripemd128_hash test failed");
			$finish;
		end
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	task automatic send_item(logic [7:0] b, logic has_byte, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		msg_byte <= b;
		byte_present <= has_byte;
		end_of_message <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		if (last)
			messages_sent++;
	endtask

	task automatic send_message(int len, logic end_with_byte);
		for (int i = 0; i < len; i++)
			send_item($urandom_range(255), 1'b1, end_with_byte && i == len - 1);
		if (!end_with_byte || len == 0)
			send_item($urandom_range(255), 1'b0, 1'b1);
	endtask

	task automatic random_phase(int n_items);
		int start_items, len;
		start_items = items_sent;
		while (items_sent - start_items < n_items) begin
			if ($urandom_range(9) == 0)
				send_item($urandom_range(255), 1'b0, 1'b0);
			else begin
				case ($urandom_range(7))
					0: len = $urandom_range(1);
					1: len = 55 + $urandom_range(2);
					2: len = 63 + $urandom_range(2);
					3: len = 119 + $urandom_range(10);
					default: len = $urandom_range(40);
				endcase
				send_message(len, $urandom_range(1));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		msg_byte = 8'h00;
		byte_present = 1'b0;
		end_of_message = 1'b0;
		items_sent = 0;
		messages_sent = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message, extremes, byte-and-end, end-only, no-op
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(8'hA5, 1'b0, 1'b0);
		send_item(8'h5A, 1'b0, 1'b0);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b0);
		send_item(8'h3C, 1'b0, 1'b1);
		for (int i = 0; i < 14; i++)
			send_item(8'h55 ^ i[7:0], 1'b1, i == 13);

		// pause until every digest is back
		in_valid <= 1'b0;
		while (pending_digests != 0)
			@(posedge clk);

		send_idle_pct = 36; recv_idle_pct = 65;
		random_phase(470);
		send_idle_pct = 65; recv_idle_pct = 36;
		random_phase(470);
		send_idle_pct = 0; recv_idle_pct = 0;
		random_phase(470);

		in_valid <= 1'b0;
		while (pending_digests != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);

		$display("covered %0d items in %0d messages, %0d digests checked",
			items_sent, messages_sent, digests_seen);
		$display("lengths spanned empty, padding boundaries and multi-block messages");
		if (mismatches == 0 && pending_digests == 0)
			$display("ripemd128_hash test passed");
		else
			$display("ripemd128_hash test failed");
		$finish;
	end
endmodule

@@ sim.f @@
rtl/core/rmd128_pkg.sv
rtl/core/rmd128_compress.sv
rtl/core/ripemd128_hash.sv
tb/ripemd128_hash_checker.sv
tb/ripemd128_hash_tb.sv
